// ----- rtl/core/esvg_pkg.sv -----
// Package for the ellipse segment vertex generator: widths, register indexes,
// quadrant codes, the CORDIC arctangent table and the sideband beat type.
// Used by every module of the block; depends on nothing.
`default_nettype none

package esvg_pkg;

   localparam int MAX_SECTIONS_DEF = 4096;
   localparam int TRIG_ITER_DEF    = 16;

   localparam int INDEX_W    = 12;
   localparam int COORD_W    = 20;
   localparam int RADIUS_W   = 16;
   localparam int SRADIUS_W  = 17;
   localparam int COUNT_W    = 13;
   localparam int SECT_W     = 17;
   localparam int PHASE_W    = 16;
   localparam int K_W        = 13;
   localparam int TRIG_W     = 32;
   localparam int Z_W        = 24;
   localparam int ATAN_W     = 22;
   localparam int FRAC_W     = 30;
   localparam int CSR_IDX_W  = 3;
   localparam int LANES      = 4;
   localparam int MIN_SECTIONS = 4;

   localparam logic signed [TRIG_W-1:0] CORDIC_START = 32'sd652032874;
   localparam logic [PHASE_W-1:0] EIGHTH_TURN = 16'd8192;
   localparam int DEG_PER_TURN = 360;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTRE_X       = 3'd0,
      CSR_CENTRE_Y       = 3'd1,
      CSR_RADIUS_X       = 3'd2,
      CSR_RADIUS_Y       = 3'd3,
      CSR_RING_THICKNESS = 3'd4,
      CSR_SECTION_COUNT  = 3'd5,
      CSR_START_PHASE    = 3'd6,
      CSR_RING_MODE      = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quadrant_type;

   typedef struct packed {
      logic valid;
      logic in_range;
      logic last;
   } sideband_type;

   // Arctangent of 2^-i in degrees times 65536.
   function automatic logic [ATAN_W-1:0] atan_deg16(input int unsigned i);
      logic [ATAN_W-1:0] v;
      case (i)
         0: v = 22'd2949120;
         1: v = 22'd1740967;
         2: v = 22'd919879;
         3: v = 22'd466945;
         4: v = 22'd234379;
         5: v = 22'd117304;
         6: v = 22'd58666;
         7: v = 22'd29335;
         8: v = 22'd14668;
         9: v = 22'd7334;
         10: v = 22'd3667;
         11: v = 22'd1833;
         12: v = 22'd917;
         13: v = 22'd458;
         14: v = 22'd229;
         15: v = 22'd115;
         16: v = 22'd57;
         17: v = 22'd29;
         18: v = 22'd14;
         19: v = 22'd7;
         20: v = 22'd4;
         21: v = 22'd2;
         22: v = 22'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/esvg_divider.sv -----
// Pipelined restoring divider giving floor(k * 32768 / divisor), one quotient
// bit per register stage. Depends on esvg_pkg.
`default_nettype none

module esvg_divider #(
   parameter int SW = 13
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [esvg_pkg::K_W-1:0]      k,
   input  wire logic [SW-1:0]                 divisor,
   output logic      [esvg_pkg::PHASE_W-1:0]  quotient
);

   localparam int RW    = SW + 1;
   localparam int STEPS = esvg_pkg::PHASE_W;
   localparam int QW    = esvg_pkg::PHASE_W;

   logic [RW-1:0] rem_ff [1:STEPS];
   logic [QW-1:0] quo_ff [1:STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [RW-1:0] cur;
      logic [QW-1:0] qcur;
      logic          ge;
      logic [RW-1:0] diff;
      logic [RW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (i == 0) begin : g_first
         assign cur  = RW'(k);
         assign qcur = '0;
      end else begin : g_next
         assign cur  = rem_ff[i];
         assign qcur = quo_ff[i];
      end

      assign ge     = cur >= {1'b0, divisor};
      assign diff   = ge ? cur - {1'b0, divisor} : cur;
      assign rem_in = {diff[RW-2:0], 1'b0};
      assign quo_in = {qcur[QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= rem_in;
            quo_ff[i+1] <= quo_in;
         end
      end
   end

   assign quotient = quo_ff[STEPS];

endmodule

`default_nettype wire

// ----- rtl/core/esvg_cordic.sv -----
// Pipelined rotation CORDIC: phase in 1/65536 turn to Q30 cosine and sine,
// one rotation per stage plus a setup and a quadrant stage. Depends on esvg_pkg.
`default_nettype none

module esvg_cordic #(
   parameter int ITER = esvg_pkg::TRIG_ITER_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic        [esvg_pkg::PHASE_W-1:0] phase,
   output logic signed      [esvg_pkg::TRIG_W-1:0]  cos_out,
   output logic signed      [esvg_pkg::TRIG_W-1:0]  sin_out
);

   localparam int TW = esvg_pkg::TRIG_W;
   localparam int ZW = esvg_pkg::Z_W;

   logic signed [TW-1:0] x_ff [0:ITER];
   logic signed [TW-1:0] y_ff [0:ITER];
   logic signed [ZW-1:0] z_ff [0:ITER];
   esvg_pkg::quadrant_type quad_ff [0:ITER];
   logic signed [TW-1:0] cos_ff, sin_ff;

   // Setup: shift by an eighth turn so the residual sits in [-1/8, 1/8) turn.
   logic [esvg_pkg::PHASE_W-1:0] p;
   logic signed [15:0]           zoff;
   logic signed [ZW-1:0]         z_in;

   assign p    = phase + esvg_pkg::EIGHTH_TURN;
   assign zoff = $signed({2'b00, p[13:0]}) - $signed({2'b00, esvg_pkg::EIGHTH_TURN[13:0]});
   assign z_in = ZW'(zoff) * $signed(ZW'(esvg_pkg::DEG_PER_TURN));

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= esvg_pkg::CORDIC_START;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_in;
         quad_ff[0] <= esvg_pkg::quadrant_type'(p[15:14]);
      end
   end

   for (genvar i = 0; i < ITER; i++) begin : g_iter
      logic signed [TW-1:0] xs, ys, x_in, y_in;
      logic signed [ZW-1:0] atan, z_in_i;
      assign xs   = x_ff[i] >>> i;
      assign ys   = y_ff[i] >>> i;
      assign atan = $signed(ZW'(esvg_pkg::atan_deg16(i)));
      always_comb begin
         if (!z_ff[i][ZW-1]) begin
            x_in   = x_ff[i] - ys;
            y_in   = y_ff[i] + xs;
            z_in_i = z_ff[i] - atan;
         end else begin
            x_in   = x_ff[i] + ys;
            y_in   = y_ff[i] - xs;
            z_in_i = z_ff[i] + atan;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in_i;
            quad_ff[i+1] <= quad_ff[i];
         end
      end
   end

   // Quadrant rotation of the final vector.
   logic signed [TW-1:0] cos_in, sin_in;
   always_comb begin
      case (quad_ff[ITER])
         esvg_pkg::QUAD_0: begin
            cos_in = x_ff[ITER];
            sin_in = y_ff[ITER];
         end
         esvg_pkg::QUAD_1: begin
            cos_in = -y_ff[ITER];
            sin_in = x_ff[ITER];
         end
         esvg_pkg::QUAD_2: begin
            cos_in = -x_ff[ITER];
            sin_in = -y_ff[ITER];
         end
         default: begin
            cos_in = y_ff[ITER];
            sin_in = -x_ff[ITER];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

`default_nettype wire

// ----- rtl/core/esvg_scale.sv -----
// Two-stage vertex scaler: multiplies Q30 trig values by the radii, rounds,
// adds the centre and saturates to 20 bits. Depends on esvg_pkg.
`default_nettype none

module esvg_scale (
   input  wire logic                                   clock,
   input  wire logic                                   en,
   input  wire logic signed [esvg_pkg::TRIG_W-1:0]     cos_in,
   input  wire logic signed [esvg_pkg::TRIG_W-1:0]     sin_in,
   input  wire logic signed [esvg_pkg::SRADIUS_W-1:0]  radius_x,
   input  wire logic signed [esvg_pkg::SRADIUS_W-1:0]  radius_y,
   input  wire logic signed [esvg_pkg::COORD_W-1:0]    centre_x,
   input  wire logic signed [esvg_pkg::COORD_W-1:0]    centre_y,
   output logic signed      [esvg_pkg::COORD_W-1:0]    point_x,
   output logic signed      [esvg_pkg::COORD_W-1:0]    point_y
);

   localparam int PW = esvg_pkg::TRIG_W + esvg_pkg::SRADIUS_W;
   localparam int FW = esvg_pkg::FRAC_W;
   localparam int TW = PW - FW;
   localparam int CW = esvg_pkg::COORD_W;
   localparam int SUMW = CW + 2;

   logic signed [PW-1:0] prod_x_ff, prod_y_ff;
   logic signed [CW-1:0] point_x_ff, point_y_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_x_ff <= PW'(cos_in) * PW'(radius_x);
         prod_y_ff <= PW'(sin_in) * PW'(radius_y);
      end
   end

   function automatic logic signed [CW-1:0] place(input logic signed [PW-1:0] prod,
                                                  input logic signed [CW-1:0] centre);
      logic signed [PW-1:0]   rounded;
      logic signed [TW-1:0]   t;
      logic signed [SUMW-1:0] sum;
      logic signed [SUMW-1:0] hi;
      logic signed [SUMW-1:0] lo;
      rounded = prod + $signed(PW'(1) <<< (FW - 1));
      t       = rounded[PW-1:FW];
      sum     = SUMW'(centre) + SUMW'(t);
      hi      = SUMW'($signed({1'b0, {(CW-1){1'b1}}}));
      lo      = SUMW'($signed({1'b1, {(CW-1){1'b0}}}));
      if (sum > hi) begin
         return hi[CW-1:0];
      end else if (sum < lo) begin
         return lo[CW-1:0];
      end
      return sum[CW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         point_x_ff <= place(prod_x_ff, centre_x);
         point_y_ff <= place(prod_y_ff, centre_y);
      end
   end

   assign point_x = point_x_ff;
   assign point_y = point_y_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ellipse_segment_vertex_generator.sv -----
// Ellipse segment vertex generator: top level with configuration registers,
// input stage, four vertex lanes and the output handshake. Depends on esvg_pkg,
// esvg_divider, esvg_cordic and esvg_scale.
`default_nettype none

// Each request beat carries a segment index n; the response beat carries the
// outer vertices a and b of that segment and, in ring mode, the inner vertices
// c and d, plus an in-range flag on tuser and a last-segment flag on tlast.
// The block accepts one beat per clock while the output is not stalled and
// returns results in order. Each beat passes one input register, the
// bit-per-stage phase divider, the CORDIC setup, rotation and quadrant stages
// and the multiply, round and saturate stages. All four vertices are worked in
// parallel lanes. The whole pipeline advances whenever the output register is
// empty or being taken, so a stalled response holds every stage in place and
// req_tready follows that same condition. Configuration is applied
// combinationally to items in flight, so write registers only while the block
// is empty.
module ellipse_segment_vertex_generator #(
   parameter int MAX_SECTIONS    = esvg_pkg::MAX_SECTIONS_DEF,
   parameter int TRIG_ITERATIONS = esvg_pkg::TRIG_ITER_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request: tdata = segment_index[11:0], zero padded.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,
   // Response: tdata = outer_ax, outer_ay, outer_bx, outer_by, inner_cx,
   // inner_cy, inner_dx, inner_dy, 20 bits each from the lowest bit up.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [159:0]      rsp_tdata,
   // tuser = in_range.
   output logic              rsp_tuser,
   // tlast = last_segment.
   output logic              rsp_tlast,
   input  wire logic                            csr_write,
   input  wire logic [esvg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [esvg_pkg::COORD_W-1:0]    csr_wdata
);

   localparam int SW      = $clog2(MAX_SECTIONS + 1);
   localparam int CW      = esvg_pkg::COORD_W;
   localparam int RW      = esvg_pkg::RADIUS_W;
   localparam int SRW     = esvg_pkg::SRADIUS_W;
   localparam int NW      = esvg_pkg::SECT_W;
   localparam int IW      = esvg_pkg::INDEX_W;
   localparam int KW      = esvg_pkg::K_W;
   localparam int L       = esvg_pkg::LANES;
   localparam int LAT     = 1 + esvg_pkg::PHASE_W + TRIG_ITERATIONS + 2 + 2;

   // Configuration registers.
   logic signed [CW-1:0]               centre_x_ff, centre_y_ff;
   logic [RW-1:0]                      radius_x_ff, radius_y_ff, thickness_ff;
   logic [esvg_pkg::COUNT_W-1:0]       section_count_ff;
   logic [esvg_pkg::PHASE_W-1:0]       start_phase_ff;
   logic                               ring_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff      <= '0;
         centre_y_ff      <= '0;
         radius_x_ff      <= '0;
         radius_y_ff      <= '0;
         thickness_ff     <= '0;
         section_count_ff <= '0;
         start_phase_ff   <= '0;
         ring_mode_ff     <= 1'b0;
      end else if (csr_write) begin
         case (esvg_pkg::csr_index_type'(csr_index))
            esvg_pkg::CSR_CENTRE_X:       centre_x_ff      <= csr_wdata;
            esvg_pkg::CSR_CENTRE_Y:       centre_y_ff      <= csr_wdata;
            esvg_pkg::CSR_RADIUS_X:       radius_x_ff      <= csr_wdata[RW-1:0];
            esvg_pkg::CSR_RADIUS_Y:       radius_y_ff      <= csr_wdata[RW-1:0];
            esvg_pkg::CSR_RING_THICKNESS: thickness_ff     <= csr_wdata[RW-1:0];
            esvg_pkg::CSR_SECTION_COUNT:
               section_count_ff <= csr_wdata[esvg_pkg::COUNT_W-1:0];
            esvg_pkg::CSR_START_PHASE:
               start_phase_ff <= csr_wdata[esvg_pkg::PHASE_W-1:0];
            esvg_pkg::CSR_RING_MODE:      ring_mode_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective section count: automatic mode takes the larger radius divided by
   // eight; both modes are clamped to [4, MAX_SECTIONS].
   logic [RW-1:0] radius_max;
   logic [NW-1:0] sect_raw, sect_cap, sect_eff;
   always_comb begin
      radius_max = (radius_x_ff > radius_y_ff) ? radius_x_ff : radius_y_ff;
      if (section_count_ff == '0) begin
         sect_raw = NW'(radius_max >> 3);
      end else begin
         sect_raw = NW'(section_count_ff);
      end
      sect_cap = (sect_raw > NW'(MAX_SECTIONS)) ? NW'(MAX_SECTIONS) : sect_raw;
      sect_eff = (sect_cap < NW'(esvg_pkg::MIN_SECTIONS)) ?
                 NW'(esvg_pkg::MIN_SECTIONS) : sect_cap;
   end

   // Pipeline advance: move when the output register is free or being taken.
   esvg_pkg::sideband_type sb_ff [0:LAT-1];
   logic en;
   assign en         = !sb_ff[LAT-1].valid || rsp_tready;
   assign req_tready = en;

   // Input stage: segment index n, its successor m, and the four numerators
   // k = 2n, 2m, 2n+1, 2m+1 over a 32768 / S step.
   logic [NW-1:0] n_ext, n_next;
   logic [IW-1:0] m_idx;
   esvg_pkg::sideband_type sb_in;
   logic [KW-1:0] k_in [0:L-1];
   logic [KW-1:0] k_ff [0:L-1];

   always_comb begin
      n_ext         = NW'(req_tdata[IW-1:0]);
      n_next        = n_ext + NW'(1);
      sb_in.valid   = req_tvalid;
      sb_in.in_range = n_ext < sect_eff;
      sb_in.last    = sb_in.in_range && (n_next == sect_eff);
      m_idx         = (n_next == sect_eff) ? '0 : n_next[IW-1:0];
      k_in[0]       = {req_tdata[IW-1:0], 1'b0};
      k_in[1]       = {m_idx, 1'b0};
      k_in[2]       = {req_tdata[IW-1:0], 1'b1};
      k_in[3]       = {m_idx, 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            sb_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         sb_ff[0] <= sb_in;
         for (int i = 1; i < LAT; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < L; i++) begin
            k_ff[i] <= k_in[i];
         end
      end
   end

   // Radii: lanes a and b use the outer radii, c and d the inner ones.
   logic signed [SRW-1:0] outer_rx, outer_ry, inner_rx, inner_ry;
   assign outer_rx = $signed({1'b0, radius_x_ff});
   assign outer_ry = $signed({1'b0, radius_y_ff});
   assign inner_rx = $signed({1'b0, radius_x_ff}) - $signed({1'b0, thickness_ff});
   assign inner_ry = $signed({1'b0, radius_y_ff}) - $signed({1'b0, thickness_ff});

   logic signed [CW-1:0] pt_x [0:L-1];
   logic signed [CW-1:0] pt_y [0:L-1];

   for (genvar g = 0; g < L; g++) begin : g_lane
      logic [esvg_pkg::PHASE_W-1:0] quotient, phase;
      logic signed [esvg_pkg::TRIG_W-1:0] cos_v, sin_v;

      esvg_divider #(.SW(SW)) u_div (
         .clock    (clock),
         .en       (en),
         .k        (k_ff[g]),
         .divisor  (sect_eff[SW-1:0]),
         .quotient (quotient)
      );

      assign phase = start_phase_ff + quotient;

      esvg_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic (
         .clock   (clock),
         .en      (en),
         .phase   (phase),
         .cos_out (cos_v),
         .sin_out (sin_v)
      );

      esvg_scale u_scale (
         .clock    (clock),
         .en       (en),
         .cos_in   (cos_v),
         .sin_in   (sin_v),
         .radius_x ((g < 2) ? outer_rx : inner_rx),
         .radius_y ((g < 2) ? outer_ry : inner_ry),
         .centre_x (centre_x_ff),
         .centre_y (centre_y_ff),
         .point_x  (pt_x[g]),
         .point_y  (pt_y[g])
      );
   end

   // Out-of-range items return all zeros; filled mode zeros the inner points.
   logic keep_outer, keep_inner;
   assign keep_outer = sb_ff[LAT-1].in_range;
   assign keep_inner = sb_ff[LAT-1].in_range && ring_mode_ff;

   assign rsp_tvalid = sb_ff[LAT-1].valid;
   assign rsp_tuser  = sb_ff[LAT-1].in_range;
   assign rsp_tlast  = sb_ff[LAT-1].last;
   assign rsp_tdata  = {
      keep_inner ? pt_y[3] : CW'(0), keep_inner ? pt_x[3] : CW'(0),
      keep_inner ? pt_y[2] : CW'(0), keep_inner ? pt_x[2] : CW'(0),
      keep_outer ? pt_y[1] : CW'(0), keep_outer ? pt_x[1] : CW'(0),
      keep_outer ? pt_y[0] : CW'(0), keep_outer ? pt_x[0] : CW'(0)
   };

endmodule

`default_nettype wire

// ----- sim/ellipse_segment_vertex_generator_tb.sv -----
// Self-checking testbench for the ellipse segment vertex generator.
// Depends on esvg_pkg and the ellipse_segment_vertex_generator RTL only.
// A local fixed-point CORDIC predictor checks every response beat in order.
`default_nettype none

module ellipse_segment_vertex_generator_tb;

   // One expected response beat: eight packed vertex coordinates plus flags.
   typedef struct {
      logic signed [esvg_pkg::COORD_W-1:0] coord[8];
      logic                                in_range;
      logic                                last;
   } vertex_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // Request tdata fields from the lowest bit up: segment_index.
   logic [15:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // Response tdata fields from the lowest bit up: outer_ax, outer_ay, outer_bx,
   // outer_by, inner_cx, inner_cy, inner_dx, inner_dy.
   logic [159:0] rsp_tdata;
   // Response tuser: in_range.
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_write = 1'b0;
   esvg_pkg::csr_index_type csr_index = esvg_pkg::CSR_CENTRE_X;
   logic [esvg_pkg::COORD_W-1:0] csr_wdata = '0;

   ellipse_segment_vertex_generator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow copy of the configuration registers, updated on every write.
   logic [19:0] shadow_cx = '0, shadow_cy = '0;
   logic [15:0] shadow_rx = '0, shadow_ry = '0, shadow_thick = '0, shadow_start = '0;
   logic [12:0] shadow_sections = '0;
   logic        shadow_ring = 1'b0;

   logic [esvg_pkg::INDEX_W-1:0] pending_indexes[$];
   vertex_set_type     expected_vertices[$];
   int error_count = 0;
   int beats_checked = 0;
   int out_of_range_beats = 0;
   int last_segment_beats = 0;
   int ring_beats = 0;
   int phase_no = 0;
   bit no_idle = 1'b0;

   // Arctangent of 2^-i in degrees times 65536, one entry per rotation step.
   localparam longint ARCTAN_DEG[16] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115};

   function automatic longint section_total();
      longint s;
      if (shadow_sections == 0)
         s = ((shadow_rx > shadow_ry) ? shadow_rx : shadow_ry) / 8;
      else
         s = shadow_sections;
      if (s > 4096) s = 4096;
      if (s < esvg_pkg::MIN_SECTIONS) s = esvg_pkg::MIN_SECTIONS;
      return s;
   endfunction

   function automatic logic signed [esvg_pkg::COORD_W-1:0] clamp_coord(input longint v);
      if (v > 524287) return 20'sd524287;
      if (v < -524288) return -20'sd524288;
      return v[esvg_pkg::COORD_W-1:0];
   endfunction

   // Rotates a unit vector to the given phase, scales it by both radii, adds the centre.
   function automatic void place_vertex(input logic [15:0] phase, input longint rx,
                                        input longint ry,
                                        output logic signed [esvg_pkg::COORD_W-1:0] ox,
                                        output logic signed [esvg_pkg::COORD_W-1:0] oy);
      logic [15:0] p;
      logic [1:0]  quad;
      longint z, x, y, xs, ys, cosv, sinv;
      p = phase + esvg_pkg::EIGHTH_TURN;
      quad = p[15:14];
      z = (longint'(p[13:0]) - 8192) * 360;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - ARCTAN_DEG[i];
         end else begin
            x = x + ys; y = y - xs; z = z + ARCTAN_DEG[i];
         end
      end
      case (quad)
         esvg_pkg::QUAD_0: begin cosv = x;  sinv = y;  end
         esvg_pkg::QUAD_1: begin cosv = -y; sinv = x;  end
         esvg_pkg::QUAD_2: begin cosv = -x; sinv = -y; end
         default: begin cosv = y; sinv = -x; end
      endcase
      ox = clamp_coord(longint'(signed'(shadow_cx)) + ((cosv * rx + (64'sd1 <<< 29)) >>> 30));
      oy = clamp_coord(longint'(signed'(shadow_cy)) + ((sinv * ry + (64'sd1 <<< 29)) >>> 30));
   endfunction

   function automatic vertex_set_type segment_vertices(
         input logic [esvg_pkg::INDEX_W-1:0] idx);
      vertex_set_type r;
      longint s, n, m, irx, iry;
      logic [15:0] pa, pb, pc, pd;
      s = section_total();
      n = idx;
      foreach (r.coord[i]) r.coord[i] = '0;
      r.in_range = 1'b0;
      r.last = 1'b0;
      if (n >= s) return r;
      m = (n + 1 == s) ? 0 : n + 1;
      r.in_range = 1'b1;
      r.last = (n + 1 == s);
      pa = shadow_start + 16'((n * 65536) / s);
      pb = shadow_start + 16'((m * 65536) / s);
      pc = shadow_start + 16'(((2 * n + 1) * 32768) / s);
      pd = shadow_start + 16'(((2 * m + 1) * 32768) / s);
      place_vertex(pa, shadow_rx, shadow_ry, r.coord[0], r.coord[1]);
      place_vertex(pb, shadow_rx, shadow_ry, r.coord[2], r.coord[3]);
      if (shadow_ring) begin
         irx = longint'(shadow_rx) - longint'(shadow_thick);
         iry = longint'(shadow_ry) - longint'(shadow_thick);
         place_vertex(pc, irx, iry, r.coord[4], r.coord[5]);
         place_vertex(pd, irx, iry, r.coord[6], r.coord[7]);
      end
      return r;
   endfunction

   // Driver: offers queued segment indexes, holding a beat until it is taken.
   // Each accepted beat is predicted right away against the current registers.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready)
            expected_vertices.push_back(
               segment_vertices(req_tdata[esvg_pkg::INDEX_W-1:0]));
         if (!req_tvalid || req_tready) begin
            if (pending_indexes.size() > 0 && (no_idle || $urandom_range(99) >= 27)) begin
               req_tvalid <= 1'b1;
               req_tdata <= {4'b0, pending_indexes.pop_front()};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response beat against the oldest prediction and
   // drives rsp_tready, including one long hold-off in the fourth phase so
   // the pipeline fills and back-pressures the request side.
   string coord_names[8] = '{"outer_ax", "outer_ay", "outer_bx", "outer_by",
                             "inner_cx", "inner_cy", "inner_dx", "inner_dy"};
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(posedge clock) begin
      vertex_set_type want;
      logic signed [esvg_pkg::COORD_W-1:0] got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_vertices.size() == 0) begin
               $error("response beat with no request outstanding");
               error_count++;
            end else begin
               want = expected_vertices.pop_front();
               beats_checked++;
               if (!want.in_range) out_of_range_beats++;
               if (want.last) last_segment_beats++;
               if (shadow_ring && want.in_range) ring_beats++;
               for (int i = 0; i < 8; i++) begin
                  got = rsp_tdata[i*esvg_pkg::COORD_W +: esvg_pkg::COORD_W];
                  if (got !== want.coord[i]) begin
                     $error("%s expected %0d got %0d", coord_names[i], want.coord[i], got);
                     error_count++;
                  end
               end
               if (rsp_tuser !== want.in_range) begin
                  $error("in_range expected %0d got %0d", want.in_range, rsp_tuser);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_segment expected %0d got %0d", want.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_done && phase_no == 3 && rsp_tvalid) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= 27);
         end
      end
   end

   task automatic write_reg(input esvg_pkg::csr_index_type idx,
                            input logic [esvg_pkg::COORD_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         esvg_pkg::CSR_CENTRE_X:       shadow_cx = value;
         esvg_pkg::CSR_CENTRE_Y:       shadow_cy = value;
         esvg_pkg::CSR_RADIUS_X:       shadow_rx = value[15:0];
         esvg_pkg::CSR_RADIUS_Y:       shadow_ry = value[15:0];
         esvg_pkg::CSR_RING_THICKNESS: shadow_thick = value[15:0];
         esvg_pkg::CSR_SECTION_COUNT:  shadow_sections = value[12:0];
         esvg_pkg::CSR_START_PHASE:    shadow_start = value[15:0];
         default:                      shadow_ring = value[0];
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_ellipse(input logic [19:0] cx, input logic [19:0] cy,
                               input logic [15:0] rx, input logic [15:0] ry,
                               input logic [15:0] thick, input logic [12:0] sections,
                               input logic [15:0] start, input logic ring);
      write_reg(esvg_pkg::CSR_CENTRE_X, cx);
      write_reg(esvg_pkg::CSR_CENTRE_Y, cy);
      write_reg(esvg_pkg::CSR_RADIUS_X, {4'b0, rx});
      write_reg(esvg_pkg::CSR_RADIUS_Y, {4'b0, ry});
      write_reg(esvg_pkg::CSR_RING_THICKNESS, {4'b0, thick});
      write_reg(esvg_pkg::CSR_SECTION_COUNT, {7'b0, sections});
      write_reg(esvg_pkg::CSR_START_PHASE, {4'b0, start});
      write_reg(esvg_pkg::CSR_RING_MODE, {19'b0, ring});
   endtask

   // Waits until every request is taken and every response is back, then
   // lets the pipeline drain before the registers may change.
   task automatic drain();
      wait (pending_indexes.size() == 0 && !req_tvalid && expected_vertices.size() == 0);
      repeat (esvg_pkg::TRIG_ITER_DEF + 30) @(posedge clock);
   endtask

   // Boundary indexes around the section count plus both bit patterns.
   task automatic queue_boundaries();
      longint s;
      s = section_total();
      @(negedge clock);
      pending_indexes.push_back(12'd0);
      pending_indexes.push_back(12'd1);
      pending_indexes.push_back(12'(s - 2));
      pending_indexes.push_back(12'(s - 1));
      if (s < 4096) pending_indexes.push_back(12'(s));
      pending_indexes.push_back(12'hFFF);
      pending_indexes.push_back(12'hAAA);
      pending_indexes.push_back(12'h555);
   endtask

   // Mostly indexes inside the ellipse, with a share of arbitrary ones.
   task automatic queue_segments(input int count);
      longint s;
      s = section_total();
      @(negedge clock);
      repeat (count) begin
         if ($urandom_range(99) < 85)
            pending_indexes.push_back(12'($urandom_range(32'(s - 1))));
         else
            pending_indexes.push_back(12'($urandom_range(4095)));
      end
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(600));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [12:0] pick_sections();
      case ($urandom_range(7))
         0, 1, 2: return 13'd0;
         3: return 13'($urandom_range(1, 3));
         4: return 13'd4096;
         5: return 13'h1FFF;
         default: return 13'($urandom_range(4, 4200));
      endcase
   endfunction

   function automatic logic [19:0] pick_centre();
      case ($urandom_range(4))
         0: return 20'h7FFFF;
         1: return 20'h80000;
         2: return 20'h0;
         default: return 20'($urandom);
      endcase
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: zero radii, automatic count, filled fan.
      queue_boundaries();
      drain();

      // Ring with a thickness beyond the radius, so inner radii go negative.
      phase_no = 1;
      load_ellipse(20'h00100, 20'hFFF00, 16'd800, 16'd300, 16'd1000, 13'd0, 16'hFFFF, 1'b1);
      queue_boundaries();
      queue_segments(60);
      drain();

      // Saturating corner: centre at the +x and -y limits with full radii, no idling.
      phase_no = 2;
      no_idle = 1'b1;
      load_ellipse(20'h7FFFF, 20'h80000, 16'hFFFF, 16'hFFFF, 16'd0, 13'd4096, 16'd0, 1'b1);
      queue_segments(150);
      drain();
      no_idle = 1'b0;

      // Long response hold-off happens here while requests keep coming.
      phase_no = 3;
      load_ellipse(20'h80000, 20'h7FFFF, 16'hFFFF, 16'd5, 16'hFFFF, 13'h1FFF, 16'h4000, 1'b1);
      queue_segments(200);
      drain();

      for (int p = 4; p < 16; p++) begin
         phase_no = p;
         load_ellipse(pick_centre(), pick_centre(), pick16(), pick16(), pick16(),
                      pick_sections(), pick16(), 1'($urandom_range(1)));
         queue_segments(120);
         drain();
      end

      $display("Checked %0d response beats over %0d register settings: %0d outside the",
               beats_checked, phase_no + 1, out_of_range_beats);
      $display("ellipse, %0d closing segments, %0d ring segments.", last_segment_beats,
               ring_beats);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
